### rtl/core/obr_pkg.sv
// Shared types and constants for the overwriting broadcast ring.
`default_nettype none
package obr_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 64;
  localparam int ID_W   = 2;

  localparam logic REQ_PUBLISH = 1'b0;
  localparam logic REQ_CONSUME = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CUR  = 4'b0010,
    ST_SLOT = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic             has;
    logic             lap;
    logic [CNT_W-1:0] seq;
  } cur_res_t;

endpackage
`default_nettype wire

### rtl/core/obr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module obr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/obr_lap_check.sv
// Reader cursor evaluation: availability, lap detection and effective sequence.
`default_nettype none
module obr_lap_check #(
  parameter int SLOTS = 8
) (
  input  wire logic [obr_pkg::CNT_W-1:0] cur_rd,
  input  wire logic                      cur_ok,
  input  wire logic [obr_pkg::CNT_W-1:0] wc,
  output obr_pkg::cur_res_t              res
);

  localparam logic [obr_pkg::CNT_W-1:0] SLOTS_C = obr_pkg::CNT_W'(SLOTS);

  logic [obr_pkg::CNT_W-1:0] cur;
  logic [obr_pkg::CNT_W-1:0] diff;
  logic [obr_pkg::CNT_W-1:0] base;

  always_comb begin
    cur      = cur_ok ? cur_rd : '0;
    diff     = wc - cur;
    base     = wc - SLOTS_C;
    res.has  = cur < wc;
    res.lap  = res.has && (diff > SLOTS_C);
    res.seq  = res.lap ? base : cur;
  end

endmodule
`default_nettype wire

### rtl/core/overwriting_broadcast_ring_top.sv
// Top level of the overwriting broadcast ring: sequencer, counters and RAMs.
//
//   channel  ports                                       transfer
//   input    start, busy, in_req_type/write_data/reader_id  start && !busy
//   result   out_valid, out_has_data/read_data/lapped/      out_valid, one cycle
//            read_seq/write_count
//
// Publish: busy stays low, so publishes run every cycle.
// Consume: cursor RAM read, then slot RAM read if a word is delivered; only
// the cursor read if the reader has caught up, none if the id is out of range.
// Busy holds off new requests. Result appears the cycle after the last step.
// Reset (rst_n low, synchronous) clears the count, cursors and sequencer.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module overwriting_broadcast_ring_top #(
  parameter int SLOTS   = 8,
  parameter int READERS = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_req_type,
  input  wire logic [obr_pkg::DATA_W-1:0]  in_write_data,
  input  wire logic [obr_pkg::ID_W-1:0]    in_reader_id,
  output logic                             out_valid,
  output logic                             out_has_data,
  output logic      [obr_pkg::DATA_W-1:0]  out_read_data,
  output logic                             out_lapped,
  output logic      [obr_pkg::CNT_W-1:0]   out_read_seq,
  output logic      [obr_pkg::CNT_W-1:0]   out_write_count
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = READERS > 1 ? $clog2(READERS) : 1;

  obr_pkg::state_t              state_r, state_nxt;
  logic [obr_pkg::CNT_W-1:0]    wc_r, wc_nxt;
  logic [CW-1:0]                id_r, id_nxt;
  obr_pkg::cur_res_t            res_r, res_nxt;
  logic [READERS-1:0]           vld_r, vld_nxt;

  logic                         valid_r, valid_nxt;
  logic                         has_r, has_nxt;
  logic [obr_pkg::DATA_W-1:0]   data_r, data_nxt;
  logic                         lap_r, lap_nxt;
  logic [obr_pkg::CNT_W-1:0]    seq_r, seq_nxt;
  logic [obr_pkg::CNT_W-1:0]    owc_r, owc_nxt;

  logic                         accept;
  logic                         id_ok;
  logic                         slot_we;
  logic [SW-1:0]                slot_raddr;
  logic [obr_pkg::DATA_W-1:0]   slot_rdata;
  logic                         cur_we;
  logic [CW-1:0]                cur_raddr;
  logic [obr_pkg::CNT_W-1:0]    cur_rdata;
  obr_pkg::cur_res_t            chk_res;

  assign busy   = (state_r != obr_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign id_ok  = (32'(in_reader_id) < READERS);

  assign slot_we    = accept && (in_req_type == obr_pkg::REQ_PUBLISH);
  assign slot_raddr = res_r.seq[SW-1:0];
  assign cur_we     = (state_r == obr_pkg::ST_SLOT);
  assign cur_raddr  = CW'(in_reader_id);

  obr_ram #(
    .WIDTH (obr_pkg::DATA_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (wc_r[SW-1:0]),
    .wdata (in_write_data),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  obr_ram #(
    .WIDTH (obr_pkg::CNT_W),
    .DEPTH (READERS)
  ) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (id_r),
    .wdata (res_r.seq + obr_pkg::CNT_W'(1)),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  obr_lap_check #(
    .SLOTS (SLOTS)
  ) u_lap_check (
    .cur_rd (cur_rdata),
    .cur_ok (vld_r[id_r]),
    .wc     (wc_r),
    .res    (chk_res)
  );

  always_comb begin
    state_nxt = state_r;
    wc_nxt    = wc_r;
    id_nxt    = id_r;
    res_nxt   = res_r;
    vld_nxt   = vld_r;
    valid_nxt = 1'b0;
    has_nxt   = 1'b0;
    data_nxt  = '0;
    lap_nxt   = 1'b0;
    seq_nxt   = '0;
    owc_nxt   = wc_r;
    unique case (state_r)
      obr_pkg::ST_IDLE: begin
        if (accept) begin
          id_nxt = CW'(in_reader_id);
          if (in_req_type == obr_pkg::REQ_PUBLISH) begin
            wc_nxt    = wc_r + obr_pkg::CNT_W'(1);
            owc_nxt   = wc_r + obr_pkg::CNT_W'(1);
            valid_nxt = 1'b1;
          end else if (!id_ok) begin
            valid_nxt = 1'b1;
          end else begin
            state_nxt = obr_pkg::ST_CUR;
          end
        end
      end
      obr_pkg::ST_CUR: begin
        res_nxt = chk_res;
        if (chk_res.has) begin
          state_nxt = obr_pkg::ST_SLOT;
        end else begin
          valid_nxt = 1'b1;
          state_nxt = obr_pkg::ST_IDLE;
        end
      end
      obr_pkg::ST_SLOT: begin
        vld_nxt[id_r] = 1'b1;
        state_nxt     = obr_pkg::ST_OUT;
      end
      obr_pkg::ST_OUT: begin
        valid_nxt = 1'b1;
        has_nxt   = 1'b1;
        data_nxt  = slot_rdata;
        lap_nxt   = res_r.lap;
        seq_nxt   = res_r.seq;
        state_nxt = obr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = obr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= obr_pkg::ST_IDLE;
      wc_r    <= '0;
      vld_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wc_r    <= wc_nxt;
      vld_r   <= vld_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    res_r  <= res_nxt;
    has_r  <= has_nxt;
    data_r <= data_nxt;
    lap_r  <= lap_nxt;
    seq_r  <= seq_nxt;
    owc_r  <= owc_nxt;
  end

  assign out_valid       = valid_r;
  assign out_has_data    = has_r;
  assign out_read_data   = data_r;
  assign out_lapped      = lap_r;
  assign out_read_seq    = seq_r;
  assign out_write_count = owc_r;

endmodule
`default_nettype wire

### sim/tb_overwriting_broadcast_ring_top.sv
// Self-checking testbench for the overwriting broadcast ring top level.
module tb_overwriting_broadcast_ring_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W = obr_pkg::DATA_W;
  localparam int CNT_W  = obr_pkg::CNT_W;
  localparam int ID_W   = obr_pkg::ID_W;

  localparam int SLOTS   = 8;
  localparam int READERS = 4;

  typedef struct packed {
    logic              has_data;
    logic [DATA_W-1:0] read_data;
    logic              lapped;
    logic [CNT_W-1:0]  read_seq;
    logic [CNT_W-1:0]  write_count;
  } ring_result_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_req_type;
  logic [DATA_W-1:0] in_write_data;
  logic [ID_W-1:0]   in_reader_id;
  logic              out_valid;
  logic              out_has_data;
  logic [DATA_W-1:0] out_read_data;
  logic              out_lapped;
  logic [CNT_W-1:0]  out_read_seq;
  logic [CNT_W-1:0]  out_write_count;

  // predictor state
  logic [DATA_W-1:0] slot_mem [SLOTS];
  logic [CNT_W-1:0]  pub_count;
  logic [CNT_W-1:0]  cursor [READERS];

  ring_result_t pending_results[$];
  ring_result_t want;
  int           mismatch_cnt;
  int           idle_pct;

  overwriting_broadcast_ring_top #(
    .SLOTS  (SLOTS),
    .READERS(READERS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_write_data  (in_write_data),
    .in_reader_id   (in_reader_id),
    .out_valid      (out_valid),
    .out_has_data   (out_has_data),
    .out_read_data  (out_read_data),
    .out_lapped     (out_lapped),
    .out_read_seq   (out_read_seq),
    .out_write_count(out_write_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_overwriting_broadcast_ring_top NOT OK");
    $finish;
  end

  // apply one accepted transaction to the ring copy and queue its result
  task automatic ring_apply(input logic req, input logic [DATA_W-1:0] data,
                            input logic [ID_W-1:0] rid);
    ring_result_t     r;
    logic [CNT_W-1:0] cur;
    r = '0;
    if (req == obr_pkg::REQ_PUBLISH) begin
      slot_mem[pub_count % SLOTS] = data;
      pub_count = pub_count + 1;
    end else if (rid < READERS) begin
      cur = cursor[rid];
      if (cur < pub_count) begin
        if (pub_count - cur > SLOTS) begin
          cur      = pub_count - SLOTS;
          r.lapped = 1'b1;
        end
        r.read_data = slot_mem[cur % SLOTS];
        r.read_seq  = cur;
        r.has_data  = 1'b1;
        cursor[rid] = cur + 1;
      end
    end
    r.write_count = pub_count;
    pending_results.push_back(r);
  endtask

  task automatic send_item(input logic req, input logic [DATA_W-1:0] data,
                           input logic [ID_W-1:0] rid);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    in_req_type   <= req;
    in_write_data <= data;
    in_reader_id  <= rid;
    do @(posedge clk); while (busy);
    ring_apply(req, data, rid);
  endtask

  task automatic note_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("MISMATCH %s: exp has=%0b data=%h lap=%0b seq=%0d wc=%0d",
               what, want.has_data, want.read_data, want.lapped, want.read_seq,
               want.write_count);
      $display("            got has=%0b data=%h lap=%0b seq=%0d wc=%0d",
               out_has_data, out_read_data, out_lapped, out_read_seq,
               out_write_count);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        want = '0;
        note_mismatch("unexpected transaction");
      end else begin
        want = pending_results.pop_front();
        if (out_has_data !== want.has_data || out_read_data !== want.read_data ||
            out_lapped !== want.lapped || out_read_seq !== want.read_seq ||
            out_write_count !== want.write_count) begin
          note_mismatch("field");
        end
      end
    end
  end

  task automatic test_empty_readers();
    for (int i = 0; i < READERS; i++) begin
      send_item(obr_pkg::REQ_CONSUME, $urandom, i[ID_W-1:0]);
    end
  endtask

  task automatic test_publish_extremes();
    send_item(obr_pkg::REQ_PUBLISH, '0, ID_W'($urandom));
    send_item(obr_pkg::REQ_PUBLISH, '1, ID_W'($urandom));
    send_item(obr_pkg::REQ_PUBLISH, 32'hAAAA_AAAA, ID_W'($urandom));
    send_item(obr_pkg::REQ_PUBLISH, 32'h5555_5555, ID_W'($urandom));
  endtask

  task automatic test_consume_in_order();
    repeat (5) send_item(obr_pkg::REQ_CONSUME, $urandom, 2'd0);
  endtask

  task automatic test_lapped_reader();
    repeat (SLOTS + 1) send_item(obr_pkg::REQ_PUBLISH, $urandom, ID_W'($urandom));
    send_item(obr_pkg::REQ_CONSUME, $urandom, 2'd1);
    send_item(obr_pkg::REQ_CONSUME, $urandom, 2'd1);
    send_item(obr_pkg::REQ_CONSUME, $urandom, 2'd3);
  endtask

  // publish share shifts in bursts so readers alternately lap and catch up
  task automatic test_random_mix(input int n_items, input int pct);
    int               pub_pct;
    int               hot_id;
    logic             req;
    logic [DATA_W-1:0] data;
    logic [ID_W-1:0]  rid;
    idle_pct = pct;
    pub_pct  = 50;
    hot_id   = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: pub_pct = 20;
          1: pub_pct = 55;
          default: pub_pct = 85;
        endcase
        hot_id = $urandom_range(READERS - 1);
      end
      req = ($urandom_range(99) < pub_pct) ? obr_pkg::REQ_PUBLISH : obr_pkg::REQ_CONSUME;
      rid = $urandom_range(1) ? hot_id[ID_W-1:0] : ID_W'($urandom_range(READERS - 1));
      case ($urandom_range(15))
        0: data = '0;
        1: data = '1;
        default: data = $urandom;
      endcase
      send_item(req, data, rid);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = obr_pkg::REQ_PUBLISH;
    in_write_data = '0;
    in_reader_id  = '0;
    mismatch_cnt  = 0;
    idle_pct      = 23;
    pub_count     = '0;
    for (int i = 0; i < SLOTS; i++) slot_mem[i] = '0;
    for (int i = 0; i < READERS; i++) cursor[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_readers();
    test_publish_extremes();
    test_consume_in_order();
    test_lapped_reader();
    test_random_mix(250, 23);
    test_random_mix(250, 48);
    test_random_mix(250, 0);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_overwriting_broadcast_ring_top OK");
    end else begin
      $display("tb_overwriting_broadcast_ring_top NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/obr_pkg.sv
rtl/core/obr_ram.sv
rtl/core/obr_lap_check.sv
rtl/core/overwriting_broadcast_ring_top.sv
sim/tb_overwriting_broadcast_ring_top.sv
